>>> hw/rtl/i2cm_pkg.sv
// shared types, codes and helpers of the i2c register access master
package i2cm_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd32;
    localparam logic [9:0]  ACK_TIMEOUT_RESET = 10'd300;

    localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ACK_FAIL = 2'd1;
    localparam logic [1:0] STATUS_INVALID  = 2'd2;

    localparam logic [1:0] STAGE_DEV  = 2'd0;
    localparam logic [1:0] STAGE_REG  = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;
    localparam logic [1:0] STAGE_RD   = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_LOAD,
        KIND_WRITE,
        KIND_READ,
        KIND_BAD_LEN
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [7:0]  byte_count;
        logic [7:0]  buf_index;
        logic [7:0]  wr_byte;
        logic        load_ok;
        logic        sda;
    } item_t;

    typedef struct packed {
        logic can_push;
        logic has_item;
    } q_stat_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_STA_A,
        PH_STA_B,
        PH_STA_C,
        PH_STA_D,
        PH_TX_SET,
        PH_TX_HI,
        PH_TX_LO,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_ACK_END,
        PH_RX_LO,
        PH_RX_HI,
        PH_RXA_LO,
        PH_RXA_HI,
        PH_RXA_END,
        PH_STP_A,
        PH_STP_B,
        PH_STP_C
    } phase_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } drive_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done;
        logic [1:0] status;
    } result_t;

    // bus drive levels on entering a phase
    function automatic drive_t enter_drive(phase_t s, drive_t cur, logic msb, logic more);
        drive_t d;
        d = cur;
        unique case (s)
            PH_STA_A:   d.sda = 1'b0;
            PH_STA_B:   d.scl = 1'b1;
            PH_STA_C:   d.sda = 1'b1;
            PH_STA_D:   d.scl = 1'b0;
            PH_TX_SET:  begin d.scl = 1'b0; d.sda = ~msb; end
            PH_TX_HI:   d.scl = 1'b1;
            PH_TX_LO:   d.scl = 1'b0;
            PH_ACK_LO:  begin d.scl = 1'b0; d.sda = 1'b0; end
            PH_ACK_HI:  d.scl = 1'b1;
            PH_ACK_END: d.scl = 1'b0;
            PH_RX_LO:   begin d.scl = 1'b0; d.sda = 1'b0; end
            PH_RX_HI:   d.scl = 1'b1;
            PH_RXA_LO:  begin d.scl = 1'b0; d.sda = more; end
            PH_RXA_HI:  d.scl = 1'b1;
            PH_RXA_END: d.scl = 1'b0;
            PH_STP_A:   begin d.scl = 1'b0; d.sda = 1'b1; end
            PH_STP_B:   d.scl = 1'b1;
            PH_STP_C:   d.sda = 1'b0;
            default:    d = cur;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/i2cm_front.sv
// input side: accepts ticks and classifies the command they carry
module i2cm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [6:0]          s_dev_addr,
    input  logic [7:0]          s_reg_addr,
    input  logic [7:0]          s_byte_count,
    input  logic [7:0]          s_buf_index,
    input  logic [7:0]          s_wr_byte,
    input  logic                s_sda_in,
    input  i2cm_pkg::q_stat_t   q_stat,
    output logic                push,
    output i2cm_pkg::item_t     push_item
);

    logic in_reset_reg;

    always_ff @(posedge aclk) begin
        in_reset_reg <= ~aresetn;
    end

    assign s_ready = q_stat.can_push & ~in_reset_reg;
    assign push    = s_valid & s_ready;

    always_comb begin
        push_item            = '0;
        push_item.dev_addr   = s_dev_addr;
        push_item.reg_addr   = s_reg_addr;
        push_item.byte_count = s_byte_count;
        push_item.buf_index  = s_buf_index;
        push_item.wr_byte    = s_wr_byte;
        push_item.sda        = s_sda_in;
        push_item.load_ok    = ({1'b0, s_buf_index} < 9'(i2cm_pkg::BUF_DEPTH));
        unique case (i2cm_pkg::cmd_t'(s_command))
            i2cm_pkg::CMD_TICK: push_item.kind = i2cm_pkg::KIND_TICK;
            i2cm_pkg::CMD_LOAD: push_item.kind = i2cm_pkg::KIND_LOAD;
            i2cm_pkg::CMD_WRITE: begin
                push_item.kind = (s_byte_count == 8'd0) ? i2cm_pkg::KIND_BAD_LEN
                                                        : i2cm_pkg::KIND_WRITE;
            end
            i2cm_pkg::CMD_READ: begin
                push_item.kind = (s_byte_count == 8'd0) ? i2cm_pkg::KIND_BAD_LEN
                                                        : i2cm_pkg::KIND_READ;
            end
            default: push_item.kind = i2cm_pkg::KIND_TICK;
        endcase
    end

endmodule

>>> hw/rtl/i2cm_queue.sv
// two-entry queue between the classifying front and the bus engine
module i2cm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  i2cm_pkg::item_t     push_item,
    input  logic                pop,
    output i2cm_pkg::item_t     head_item,
    output i2cm_pkg::q_stat_t   q_stat
);

    i2cm_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign q_stat.can_push = (count_reg != 2'd2);
    assign q_stat.has_item = (count_reg != 2'd0);
    assign do_push   = push & q_stat.can_push;
    assign do_pop    = pop & q_stat.has_item;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/i2cm_back.sv
// bus engine: phase sequencer, write buffer, config registers and result register
module i2cm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  i2cm_pkg::q_stat_t   q_stat,
    input  i2cm_pkg::item_t     head_item,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output i2cm_pkg::result_t   m_result
);

    logic [15:0]       phase_ticks_reg;
    logic [9:0]        ack_timeout_reg;

    i2cm_pkg::phase_t  state_reg, state_next;
    logic [15:0]       timer_reg, timer_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;
    logic [7:0]        byte_cnt_reg, byte_cnt_next;
    logic [7:0]        shift_reg, shift_next;
    logic [9:0]        ack_wait_reg, ack_wait_next;
    logic [6:0]        dev_addr_reg, dev_addr_next;
    logic [7:0]        reg_addr_reg, reg_addr_next;
    logic [7:0]        length_reg, length_next;
    logic              read_mode_reg, read_mode_next;
    logic [1:0]        stage_reg, stage_next;
    logic              fail_reg, fail_next;
    i2cm_pkg::drive_t  drv_reg, drv_next;

    logic [7:0]        mem [i2cm_pkg::BUF_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [i2cm_pkg::BUF_AW-1:0] rd_addr;
    logic              mem_we;

    i2cm_pkg::result_t res_reg, res_next;
    logic              m_valid_reg;

    logic [15:0]       limit;
    logic [16:0]       timer_inc;
    logic              fire;
    logic              do_go;
    i2cm_pkg::phase_t  go_to;
    logic [8:0]        byte_inc;
    logic [8:0]        next_idx;

    assign cfg_ready = 1'b1;
    assign pop       = q_stat.has_item & (~m_valid_reg | m_ready);
    assign m_valid   = m_valid_reg;
    assign m_result  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == i2cm_pkg::CFG_PHASE_TICKS) begin
                phase_ticks_reg <= cfg_data;
            end else if (cfg_index == i2cm_pkg::CFG_ACK_TIMEOUT) begin
                ack_timeout_reg <= cfg_data[9:0];
            end
        end
    end

    // prefetch of the next data byte, stable long before it is sent
    assign next_idx = (stage_reg == i2cm_pkg::STAGE_DATA) ? ({1'b0, byte_cnt_reg} + 9'd1)
                                                          : 9'd0;
    assign rd_addr  = i2cm_pkg::BUF_AW'(next_idx % i2cm_pkg::BUF_DEPTH);
    assign mem_we   = pop & (state_reg == i2cm_pkg::PH_IDLE)
                    & (head_item.kind == i2cm_pkg::KIND_LOAD) & head_item.load_ok;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[head_item.buf_index[i2cm_pkg::BUF_AW-1:0]] <= head_item.wr_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign limit     = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
    assign timer_inc = {1'b0, timer_reg} + 17'd1;
    assign fire      = (timer_inc >= {1'b0, limit});
    assign byte_inc  = {1'b0, byte_cnt_reg} + 9'd1;

    always_comb begin
        state_next     = state_reg;
        timer_next     = timer_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        shift_next     = shift_reg;
        ack_wait_next  = ack_wait_reg;
        dev_addr_next  = dev_addr_reg;
        reg_addr_next  = reg_addr_reg;
        length_next    = length_reg;
        read_mode_next = read_mode_reg;
        stage_next     = stage_reg;
        fail_next      = fail_reg;
        drv_next       = drv_reg;
        do_go          = 1'b0;
        go_to          = i2cm_pkg::PH_IDLE;
        res_next       = '0;

        if (state_reg == i2cm_pkg::PH_IDLE) begin
            case (head_item.kind)
                i2cm_pkg::KIND_BAD_LEN: begin
                    res_next.done   = 1'b1;
                    res_next.status = i2cm_pkg::STATUS_INVALID;
                end
                i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ: begin
                    dev_addr_next  = head_item.dev_addr;
                    reg_addr_next  = head_item.reg_addr;
                    length_next    = head_item.byte_count;
                    read_mode_next = (head_item.kind == i2cm_pkg::KIND_READ);
                    stage_next     = i2cm_pkg::STAGE_DEV;
                    fail_next      = 1'b0;
                    byte_cnt_next  = 8'd0;
                    do_go          = 1'b1;
                    go_to          = i2cm_pkg::PH_STA_A;
                end
                default: ;
            endcase
        end else begin
            timer_next = timer_inc[15:0];
            if (fire) begin
                unique case (state_reg)
                    i2cm_pkg::PH_STA_A: begin do_go = 1'b1; go_to = i2cm_pkg::PH_STA_B; end
                    i2cm_pkg::PH_STA_B: begin do_go = 1'b1; go_to = i2cm_pkg::PH_STA_C; end
                    i2cm_pkg::PH_STA_C: begin do_go = 1'b1; go_to = i2cm_pkg::PH_STA_D; end
                    i2cm_pkg::PH_STA_D: begin
                        shift_next   = {dev_addr_reg, (stage_reg == i2cm_pkg::STAGE_RD)};
                        bit_cnt_next = 4'd0;
                        do_go        = 1'b1;
                        go_to        = i2cm_pkg::PH_TX_SET;
                    end
                    i2cm_pkg::PH_TX_SET: begin do_go = 1'b1; go_to = i2cm_pkg::PH_TX_HI; end
                    i2cm_pkg::PH_TX_HI:  begin do_go = 1'b1; go_to = i2cm_pkg::PH_TX_LO; end
                    i2cm_pkg::PH_TX_LO: begin
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        do_go        = 1'b1;
                        if (bit_cnt_reg + 4'd1 < 4'd8) begin
                            go_to = i2cm_pkg::PH_TX_SET;
                        end else begin
                            ack_wait_next = 10'd0;
                            go_to         = i2cm_pkg::PH_ACK_LO;
                        end
                    end
                    i2cm_pkg::PH_ACK_LO: begin do_go = 1'b1; go_to = i2cm_pkg::PH_ACK_HI; end
                    i2cm_pkg::PH_ACK_HI: begin
                        do_go = 1'b1;
                        if (!head_item.sda) begin
                            go_to = i2cm_pkg::PH_ACK_END;
                        end else if (ack_wait_reg >= ack_timeout_reg) begin
                            fail_next = 1'b1;
                            go_to     = i2cm_pkg::PH_STP_A;
                        end else begin
                            ack_wait_next = ack_wait_reg + 10'd1;
                            go_to         = i2cm_pkg::PH_ACK_HI;
                        end
                    end
                    i2cm_pkg::PH_ACK_END: begin
                        do_go = 1'b1;
                        case (stage_reg)
                            i2cm_pkg::STAGE_DEV: begin
                                stage_next   = i2cm_pkg::STAGE_REG;
                                shift_next   = reg_addr_reg;
                                bit_cnt_next = 4'd0;
                                go_to        = i2cm_pkg::PH_TX_SET;
                            end
                            i2cm_pkg::STAGE_REG: begin
                                if (read_mode_reg) begin
                                    stage_next = i2cm_pkg::STAGE_RD;
                                    go_to      = i2cm_pkg::PH_STA_A;
                                end else begin
                                    stage_next    = i2cm_pkg::STAGE_DATA;
                                    byte_cnt_next = 8'd0;
                                    shift_next    = rd_data_reg;
                                    bit_cnt_next  = 4'd0;
                                    go_to         = i2cm_pkg::PH_TX_SET;
                                end
                            end
                            i2cm_pkg::STAGE_DATA: begin
                                byte_cnt_next = byte_inc[7:0];
                                if (byte_inc[7:0] >= length_reg) begin
                                    go_to = i2cm_pkg::PH_STP_A;
                                end else begin
                                    shift_next   = rd_data_reg;
                                    bit_cnt_next = 4'd0;
                                    go_to        = i2cm_pkg::PH_TX_SET;
                                end
                            end
                            default: begin
                                byte_cnt_next = 8'd0;
                                shift_next    = 8'd0;
                                bit_cnt_next  = 4'd0;
                                go_to         = i2cm_pkg::PH_RX_LO;
                            end
                        endcase
                    end
                    i2cm_pkg::PH_RX_LO: begin do_go = 1'b1; go_to = i2cm_pkg::PH_RX_HI; end
                    i2cm_pkg::PH_RX_HI: begin
                        shift_next   = {shift_reg[6:0], head_item.sda};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        do_go        = 1'b1;
                        if (bit_cnt_reg + 4'd1 >= 4'd8) begin
                            res_next.rx_valid = 1'b1;
                            res_next.rx_byte  = {shift_reg[6:0], head_item.sda};
                            res_next.rx_index = byte_cnt_reg;
                            go_to             = i2cm_pkg::PH_RXA_LO;
                        end else begin
                            go_to = i2cm_pkg::PH_RX_LO;
                        end
                    end
                    i2cm_pkg::PH_RXA_LO: begin do_go = 1'b1; go_to = i2cm_pkg::PH_RXA_HI; end
                    i2cm_pkg::PH_RXA_HI: begin do_go = 1'b1; go_to = i2cm_pkg::PH_RXA_END; end
                    i2cm_pkg::PH_RXA_END: begin
                        byte_cnt_next = byte_inc[7:0];
                        do_go         = 1'b1;
                        if (byte_inc[7:0] >= length_reg) begin
                            go_to = i2cm_pkg::PH_STP_A;
                        end else begin
                            shift_next   = 8'd0;
                            bit_cnt_next = 4'd0;
                            go_to        = i2cm_pkg::PH_RX_LO;
                        end
                    end
                    i2cm_pkg::PH_STP_A: begin do_go = 1'b1; go_to = i2cm_pkg::PH_STP_B; end
                    i2cm_pkg::PH_STP_B: begin do_go = 1'b1; go_to = i2cm_pkg::PH_STP_C; end
                    default: begin
                        res_next.done   = 1'b1;
                        res_next.status = fail_reg ? i2cm_pkg::STATUS_ACK_FAIL
                                                   : i2cm_pkg::STATUS_OK;
                        state_next      = i2cm_pkg::PH_IDLE;
                        timer_next      = 16'd0;
                        drv_next.scl    = 1'b1;
                        drv_next.sda    = 1'b0;
                    end
                endcase
            end
        end

        if (do_go) begin
            state_next = go_to;
            timer_next = 16'd0;
            drv_next   = i2cm_pkg::enter_drive(go_to, drv_reg, shift_next[7],
                                               ({1'b0, byte_cnt_next} + 9'd1) <
                                               {1'b0, length_next});
        end

        res_next.scl_level    = drv_next.scl;
        res_next.sda_pull_low = drv_next.sda;
        res_next.busy         = (state_next != i2cm_pkg::PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= i2cm_pkg::PH_IDLE;
            timer_reg     <= 16'd0;
            bit_cnt_reg   <= 4'd0;
            byte_cnt_reg  <= 8'd0;
            shift_reg     <= 8'd0;
            ack_wait_reg  <= 10'd0;
            dev_addr_reg  <= 7'd0;
            reg_addr_reg  <= 8'd0;
            length_reg    <= 8'd0;
            read_mode_reg <= 1'b0;
            stage_reg     <= i2cm_pkg::STAGE_DEV;
            fail_reg      <= 1'b0;
            drv_reg       <= '{scl: 1'b1, sda: 1'b0};
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                state_reg     <= state_next;
                timer_reg     <= timer_next;
                bit_cnt_reg   <= bit_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                shift_reg     <= shift_next;
                ack_wait_reg  <= ack_wait_next;
                dev_addr_reg  <= dev_addr_next;
                reg_addr_reg  <= reg_addr_next;
                length_reg    <= length_next;
                read_mode_reg <= read_mode_next;
                stage_reg     <= stage_next;
                fail_reg      <= fail_next;
                drv_reg       <= drv_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> hw/rtl/i2c_master_register_access.sv
// top level of the i2c register access master
//
// every transaction on the s_ channel is one bus tick: it carries the sampled
// sda level and an optional command (load buffer byte, start register write,
// start register read). every accepted tick yields exactly one transaction on
// the m_ channel with the scl/sda drive levels, busy, any received byte and the
// done/status pair. the cfg channel writes phase_ticks (index 0) and
// ack_timeout (index 1) and is always ready; write it only while idle.
// the accepted tick is written into the two-entry queue, and the phase
// sequencer pops it from there and loads the result register. throughput is
// one tick per cycle while m_ready is high, as the sequencer steps once per
// tick. when m_ready is low a valid result holds in the result register, the
// queue fills and s_ready drops after at most two further ticks.
// reset clears the sequencer to idle with scl released high and sda released,
// restores phase_ticks 32 and ack_timeout 300; the write buffer keeps no reset
// and a buffer entry must be loaded before a write sends it.
module i2c_master_register_access (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [6:0]  s_dev_addr,
    input  logic [7:0]  s_reg_addr,
    input  logic [7:0]  s_byte_count,
    input  logic [7:0]  s_buf_index,
    input  logic [7:0]  s_wr_byte,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_pull_low,
    output logic        m_busy_res,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_byte,
    output logic [7:0]  m_rx_index,
    output logic        m_done_res,
    output logic [1:0]  m_status
);

    i2cm_pkg::q_stat_t q_stat;
    i2cm_pkg::item_t   push_item;
    i2cm_pkg::item_t   head_item;
    i2cm_pkg::result_t result;
    logic              push;
    logic              pop;

    i2cm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_dev_addr   (s_dev_addr),
        .s_reg_addr   (s_reg_addr),
        .s_byte_count (s_byte_count),
        .s_buf_index  (s_buf_index),
        .s_wr_byte    (s_wr_byte),
        .s_sda_in     (s_sda_in),
        .q_stat       (q_stat),
        .push         (push),
        .push_item    (push_item)
    );

    i2cm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    i2cm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_scl_level    = result.scl_level;
    assign m_sda_pull_low = result.sda_pull_low;
    assign m_busy_res     = result.busy;
    assign m_rx_valid     = result.rx_valid;
    assign m_rx_byte      = result.rx_byte;
    assign m_rx_index     = result.rx_index;
    assign m_done_res     = result.done;
    assign m_status       = result.status;

endmodule

>>> hw/rtl/i2cm_checker.sv
// port-level checks of the i2c register access master and their bind
module i2cm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_level,
    input logic       m_sda_pull_low,
    input logic       m_busy_res,
    input logic       m_rx_valid,
    input logic [7:0] m_rx_byte,
    input logic [7:0] m_rx_index,
    input logic       m_done_res,
    input logic [1:0] m_status
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_level)
                                && $stable(m_sda_pull_low) && $stable(m_status))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done shown while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_status == 2'd0)
        else $error("status without done");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rx_valid |-> m_rx_byte == 8'd0 && m_rx_index == 8'd0)
        else $error("rx fields set without rx_valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rx_valid |-> m_busy_res && !m_done_res)
        else $error("byte received outside a transaction");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_scl_level    (m_scl_level),
    .m_sda_pull_low (m_sda_pull_low),
    .m_busy_res     (m_busy_res),
    .m_rx_valid     (m_rx_valid),
    .m_rx_byte      (m_rx_byte),
    .m_rx_index     (m_rx_index),
    .m_done_res     (m_done_res),
    .m_status       (m_status)
);
